>>> design/sorted_node_child_lookup_top_macros.svh
// assertion helpers for the sorted node child lookup block
`ifndef SORTED_NODE_CHILD_LOOKUP_TOP_MACROS_SVH
`define SORTED_NODE_CHILD_LOOKUP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk_i, off during reset
`define SNC_ASSERT_IMP(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SNC_ASSERT_NEXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`else

`define SNC_ASSERT_IMP(label, ant, cons, msg)
`define SNC_ASSERT_NEXT(label, ant, cons, msg)

`endif

`endif

>>> design/snc_pkg.sv
package snc_pkg;

  // fixed field widths of the transaction payloads
  localparam int KIND_W   = 3;
  localparam int KEY_IN_W = 32;
  localparam int CHILD_W  = 31;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP       = 3'd0,
    KIND_INSERT_AFTER = 3'd1,
    KIND_REMOVE_SLOT  = 3'd2,
    KIND_NEW_ROOT     = 3'd3,
    KIND_FIND_CHILD   = 3'd4,
    KIND_SET_KEY      = 3'd5,
    KIND_READ_SLOT    = 3'd6,
    KIND_CLEAR        = 3'd7
  } kind_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_CHILD = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_CHK,
    S_LK_CMP,
    S_SCAN,
    S_SHUP,
    S_PUT,
    S_SHDN,
    S_ROOT,
    S_ROOT2,
    S_RDW,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic [KEY_IN_W-1:0] key;
    logic [CHILD_W-1:0]  child_a;
    logic [CHILD_W-1:0]  child_b;
    logic [SLOT_W-1:0]   slot;
  } in_t;

  typedef struct packed {
    logic [CHILD_W-1:0]  child;
    logic [SLOT_W-1:0]   found_slot;
    logic [KEY_IN_W-1:0] key_out;
    status_e             status;
    logic [COUNT_W-1:0]  count;
  } out_t;

endpackage

>>> design/snc_ram.sv
module snc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sorted_node_child_lookup_top.sv
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   in_t  (kind, key, child_a, child_b, slot)
// out      out  out_valid_o / out_ready_i out_t (child, found_slot, key_out, status, count)
//
// one item at a time; every memory read goes through a registered read port
// lookup: accept, binary-search probes (issue, compare), final child read, done
// insert: accept, scan, up-shift, put, done; remove: accept, shift down, done
// find_child: accept, scan, done; read_slot: accept, read, done
// new_root: accept, root writes, done; reset clears the slot count and the sequencer, not the memories
// a result waits in the output register; the next item runs into it and holds until taken
`include "sorted_node_child_lookup_top_macros.svh"

module sorted_node_child_lookup_top
  import snc_pkg::*;
#(
  parameter int NODE_SLOTS = 64,
  parameter int KEY_BITS   = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int AW = $clog2(NODE_SLOTS);
  localparam int CW = $clog2(NODE_SLOTS + 1);
  localparam int PW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(NODE_SLOTS);

  state_e state_q, state_d;

  kind_e                kind_q, kind_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [CHILD_W-1:0]   ca_q, ca_d;
  logic [CHILD_W-1:0]   cb_q, cb_d;
  logic [AW-1:0]        sidx_q, sidx_d;
  logic [CW-1:0]        occ_q, occ_d;
  logic [CW-1:0]        lo_q, lo_d;
  logic [CW-1:0]        hi_q, hi_d;
  logic [AW-1:0]        best_q, best_d;
  logic [AW-1:0]        mid_q, mid_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic                 rv_q, rv_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [CHILD_W-1:0]   rchild_q, rchild_d;
  logic [AW-1:0]        rslot_q, rslot_d;
  logic [KEY_BITS-1:0]  rkey_q, rkey_d;
  status_e              rstatus_q, rstatus_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  // memory ports
  logic                key_we, child_we;
  logic [AW-1:0]       key_waddr, key_raddr, child_waddr, child_raddr;
  logic [KEY_BITS-1:0] key_wdata, key_rdata;
  logic [CHILD_W-1:0]  child_wdata, child_rdata;

  // shared decode
  logic                acc, few_slots, bad_slot, match, scan_more, is_full;
  logic                lk_go, shup_more, shdn_more, out_free;
  logic [PW-1:0]       s_w, occ_w;
  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid_w;
  logic [KEY_BITS-1:0] in_key;

  assign acc       = in_valid_i && in_ready_o;
  assign in_key    = KEY_BITS'(in_data_i.key);
  assign s_w       = PW'(in_data_i.slot);
  assign occ_w     = PW'(occ_q);
  assign bad_slot  = s_w >= occ_w;
  assign few_slots = occ_q < CW'(2);
  assign match     = rv_q && (child_rdata == ca_q);
  assign scan_more = ptr_q < occ_q;
  assign is_full   = occ_q == FULL_CNT;
  assign lk_go     = lo_q <= hi_q;
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w     = mid_sum[CW:1];
  assign shup_more = ptr_q > CW'(pos_q);
  assign shdn_more = ptr_q < occ_q;
  assign out_free  = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  snc_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(NODE_SLOTS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  snc_ram #(
    .WIDTH(CHILD_W),
    .DEPTH(NODE_SLOTS)
  ) u_child_ram (
    .clk_i  (clk_i),
    .we_i   (child_we),
    .waddr_i(child_waddr),
    .wdata_i(child_wdata),
    .raddr_i(child_raddr),
    .rdata_o(child_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (in_data_i.kind)
            KIND_LOOKUP:       state_d = few_slots ? S_DONE : S_LK_CHK;
            KIND_INSERT_AFTER: state_d = S_SCAN;
            KIND_FIND_CHILD:   state_d = S_SCAN;
            KIND_REMOVE_SLOT:  state_d = bad_slot ? S_DONE : S_SHDN;
            KIND_NEW_ROOT:     state_d = S_ROOT;
            KIND_READ_SLOT:    state_d = bad_slot ? S_DONE : S_RDW;
            default:           state_d = S_DONE;
          endcase
        end
      end
      S_LK_CHK: state_d = lk_go ? S_LK_CMP : S_RDW;
      S_LK_CMP: state_d = S_LK_CHK;
      S_SCAN: begin
        if (match) begin
          state_d = (kind_q == KIND_FIND_CHILD || is_full) ? S_DONE : S_SHUP;
        end else if (!scan_more) begin
          state_d = S_DONE;
        end
      end
      S_SHUP: begin
        if (!shup_more && !rv_q) begin
          state_d = S_PUT;
        end
      end
      S_PUT:   state_d = S_DONE;
      S_SHDN: begin
        if (!shdn_more && !rv_q) begin
          state_d = S_DONE;
        end
      end
      S_ROOT:  state_d = S_ROOT2;
      S_ROOT2: state_d = S_DONE;
      S_RDW:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kind_d      = kind_q;
    key_d       = key_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    sidx_d      = sidx_q;
    occ_d       = occ_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    best_d      = best_q;
    mid_d       = mid_q;
    ptr_d       = ptr_q;
    rv_d        = rv_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    rchild_d    = rchild_q;
    rslot_d     = rslot_q;
    rkey_d      = rkey_q;
    rstatus_d   = rstatus_q;
    key_we      = 1'b0;
    key_waddr   = '0;
    key_wdata   = '0;
    key_raddr   = '0;
    child_we    = 1'b0;
    child_waddr = '0;
    child_wdata = '0;
    child_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          kind_d    = in_data_i.kind;
          key_d     = in_key;
          ca_d      = in_data_i.child_a;
          cb_d      = in_data_i.child_b;
          sidx_d    = s_w[AW-1:0];
          rchild_d  = '0;
          rslot_d   = '0;
          rkey_d    = '0;
          rstatus_d = ST_OK;
          rv_d      = 1'b0;
          ptr_d     = '0;
          case (in_data_i.kind)
            KIND_LOOKUP: begin
              if (few_slots) begin
                rstatus_d = ST_BAD_SLOT;
              end else begin
                lo_d   = CW'(1);
                hi_d   = occ_q - CW'(1);
                best_d = '0;
              end
            end
            KIND_REMOVE_SLOT: begin
              if (bad_slot) begin
                rstatus_d = ST_BAD_SLOT;
              end else begin
                ptr_d = s_w[CW-1:0];
              end
            end
            KIND_SET_KEY: begin
              if (bad_slot) begin
                rstatus_d = ST_BAD_SLOT;
              end else begin
                key_we    = 1'b1;
                key_waddr = s_w[AW-1:0];
                key_wdata = in_key;
                rslot_d   = s_w[AW-1:0];
                rkey_d    = in_key;
              end
            end
            KIND_READ_SLOT: begin
              if (bad_slot) begin
                rstatus_d = ST_BAD_SLOT;
              end else begin
                key_raddr   = s_w[AW-1:0];
                child_raddr = s_w[AW-1:0];
                rslot_d     = s_w[AW-1:0];
              end
            end
            KIND_CLEAR: begin
              occ_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // binary search probe issue, or final child read
      S_LK_CHK: begin
        if (lk_go) begin
          key_raddr = mid_w[AW-1:0];
          mid_d     = mid_w[AW-1:0];
        end else begin
          child_raddr = best_q;
          rslot_d     = best_q;
        end
      end

      // probe compare
      S_LK_CMP: begin
        if (key_rdata <= key_q) begin
          best_d = mid_q;
          lo_d   = CW'(mid_q) + CW'(1);
        end else begin
          hi_d = CW'(mid_q) - CW'(1);
        end
      end

      // pipelined scan for the lowest slot holding child_a
      S_SCAN: begin
        if (match) begin
          pos_d = idx_q;
          rv_d  = 1'b0;
          if (kind_q == KIND_FIND_CHILD) begin
            rchild_d = ca_q;
            rslot_d  = idx_q;
          end else if (is_full) begin
            rstatus_d = ST_FULL;
          end else begin
            ptr_d = occ_q - CW'(1);
          end
        end else if (scan_more) begin
          child_raddr = ptr_q[AW-1:0];
          rv_d        = 1'b1;
          idx_d       = ptr_q[AW-1:0];
          ptr_d       = ptr_q + CW'(1);
        end else begin
          rstatus_d = ST_NO_CHILD;
        end
      end

      // move slots above the insert point up by one, top first
      S_SHUP: begin
        if (rv_q) begin
          key_we      = 1'b1;
          key_waddr   = idx_q + AW'(1);
          key_wdata   = key_rdata;
          child_we    = 1'b1;
          child_waddr = idx_q + AW'(1);
          child_wdata = child_rdata;
        end
        if (shup_more) begin
          key_raddr   = ptr_q[AW-1:0];
          child_raddr = ptr_q[AW-1:0];
          rv_d        = 1'b1;
          idx_d       = ptr_q[AW-1:0];
          ptr_d       = ptr_q - CW'(1);
        end else begin
          rv_d = 1'b0;
        end
      end

      // store the new slot
      S_PUT: begin
        key_we      = 1'b1;
        key_waddr   = pos_q + AW'(1);
        key_wdata   = key_q;
        child_we    = 1'b1;
        child_waddr = pos_q + AW'(1);
        child_wdata = cb_q;
        occ_d       = occ_q + CW'(1);
        rchild_d    = cb_q;
        rslot_d     = pos_q + AW'(1);
      end

      // read the removed slot, then move later slots down by one
      S_SHDN: begin
        if (rv_q) begin
          if (idx_q == sidx_q) begin
            rchild_d = child_rdata;
          end else begin
            key_we      = 1'b1;
            key_waddr   = idx_q - AW'(1);
            key_wdata   = key_rdata;
            child_we    = 1'b1;
            child_waddr = idx_q - AW'(1);
            child_wdata = child_rdata;
          end
        end
        if (shdn_more) begin
          key_raddr   = ptr_q[AW-1:0];
          child_raddr = ptr_q[AW-1:0];
          rv_d        = 1'b1;
          idx_d       = ptr_q[AW-1:0];
          ptr_d       = ptr_q + CW'(1);
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            occ_d   = occ_q - CW'(1);
            rslot_d = sidx_q;
          end
        end
      end

      // two-entry root: old child in slot 0, key and new child in slot 1
      S_ROOT: begin
        child_we    = 1'b1;
        child_waddr = '0;
        child_wdata = ca_q;
        key_we      = 1'b1;
        key_waddr   = AW'(1);
        key_wdata   = key_q;
      end
      S_ROOT2: begin
        child_we    = 1'b1;
        child_waddr = AW'(1);
        child_wdata = cb_q;
        occ_d       = CW'(2);
        rchild_d    = cb_q;
        rslot_d     = AW'(1);
        rkey_d      = key_q;
      end

      // read data returns
      S_RDW: begin
        rchild_d = child_rdata;
        if (kind_q == KIND_READ_SLOT) begin
          rkey_d = key_rdata;
        end
      end

      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_valid_d      = 1'b1;
      out_d.child      = rchild_q;
      out_d.found_slot = SLOT_W'(rslot_q);
      out_d.key_out    = KEY_IN_W'(rkey_q);
      out_d.status     = rstatus_q;
      out_d.count      = COUNT_W'(occ_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    key_q     <= key_d;
    ca_q      <= ca_d;
    cb_q      <= cb_d;
    sidx_q    <= sidx_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    best_q    <= best_d;
    mid_q     <= mid_d;
    ptr_q     <= ptr_d;
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    rchild_q  <= rchild_d;
    rslot_q   <= rslot_d;
    rkey_q    <= rkey_d;
    rstatus_q <= rstatus_d;
    out_q     <= out_d;
  end

  // checks
  `SNC_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= FULL_CNT, "slot count above node size")
  `SNC_ASSERT_NEXT(a_busy_after_accept, acc, state_q != S_IDLE, "accepted item left no work")
  `SNC_ASSERT_IMP(a_shup_range, child_we && state_q == S_SHUP, CW'(child_waddr) <= occ_q, "up-shift wrote past count")
  `SNC_ASSERT_NEXT(a_done_shows, state_q == S_DONE && out_free, out_valid_o && state_q == S_IDLE, "finished result not shown")

endmodule
